/* rtl/core/bqd_pkg.sv */
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types and constants for the bounded message queue with drop policy.
// ----------------------------------------------------------------------------
package bqd_pkg;

	// request codes on req_type
	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_t;

	// configuration register indexes
	typedef enum logic {
		CFG_QUEUE_LIMIT = 1'b0,
		CFG_DROP_OLDEST = 1'b1
	} cfg_idx_t;

	// fixed field widths of the ports
	localparam int unsigned PAYLOAD_W = 32;
	localparam int unsigned LEVEL_W   = 11;
	localparam int unsigned LOST_W    = 32;

	// reset value of the queue limit register
	localparam logic [LEVEL_W-1:0] LIMIT_RESET = 11'd1024;

	// request-side control into the slot store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

/* rtl/core/bqd_store.sv */
// ----------------------------------------------------------------------------
// bqd_store
// Slot memory of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bqd_store #(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  bqd_pkg::store_ctl_t      ctl,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0]    wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0]    rd_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/bounded_queue_with_drop_policy.sv */
// ----------------------------------------------------------------------------
// bounded_queue_with_drop_policy
// Message FIFO whose occupancy is capped by a programmable limit, with a
// selectable overflow policy (discard new word or discard oldest word).
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | req_type, payload
//  out      | out_valid/ out_stall | pop_valid, pop_data, lost_event,
//           |                      | fill_level, is_empty, lost_total, peak_level
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  A push or an empty pop writes its result straight into the result register;
//  a pop that returns a word first passes through the registered read of the slot memory.
//  Reset clears head, level, lost counter and peak; slots are not cleared.
//  in_stall is high while a pop read is in flight or the result waits on
//  out_stall.
// ----------------------------------------------------------------------------
module bounded_queue_with_drop_policy #(
	parameter int unsigned DEPTH      = 1024,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bqd_pkg::LEVEL_W-1:0]   cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [bqd_pkg::PAYLOAD_W-1:0] payload,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          pop_valid,
	output logic [bqd_pkg::PAYLOAD_W-1:0] pop_data,
	output logic                          lost_event,
	output logic [bqd_pkg::LEVEL_W-1:0]   fill_level,
	output logic                          is_empty,
	output logic [bqd_pkg::LOST_W-1:0]    lost_total,
	output logic [bqd_pkg::LEVEL_W-1:0]   peak_level
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = (CW > bqd_pkg::LEVEL_W) ? CW : bqd_pkg::LEVEL_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);
	localparam logic [LW-1:0] DEPTH_LIM = LW'(DEPTH);
	localparam logic [LW-1:0] ONE_LIM   = LW'(1);

	// configuration registers
	logic [bqd_pkg::LEVEL_W-1:0] limit_q;
	logic                        drop_q;

	// queue state
	logic [AW-1:0]                head_q;
	logic [CW-1:0]                count_q;
	logic [bqd_pkg::LOST_W-1:0]   lost_q;
	logic [CW-1:0]                peak_q;

	// result register and pop read in flight
	logic                          out_valid_q;
	logic                          pop_valid_q;
	logic [bqd_pkg::PAYLOAD_W-1:0] pop_data_q;
	logic                          lost_event_q;
	logic                          pend_s1;

	// combinational request decode
	logic                  in_acc;
	logic                  out_take;
	logic                  is_pop;
	logic                  nonempty;
	logic                  rd_issue;
	logic [LW-1:0]         lim_raw;
	logic [LW-1:0]         eff_lim;
	logic [LW-1:0]         count_ext;
	logic                  over;
	logic [CW:0]           addr_sum;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         head_inc;
	logic [CW-1:0]         count_nxt;
	logic [AW-1:0]         head_nxt;
	logic [DATA_WIDTH-1:0] rd_data;
	bqd_pkg::store_ctl_t   store_ctl;

	// handshake
	assign in_stall = pend_s1 || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign is_pop   = (bqd_pkg::req_t'(req_type) == bqd_pkg::REQ_POP);
	assign nonempty = (count_q != '0);
	assign rd_issue = in_acc && is_pop && nonempty;

	// effective limit clamped to one .. DEPTH
	always_comb begin
		lim_raw   = LW'(limit_q);
		count_ext = LW'(count_q);
		if (lim_raw == '0) begin
			eff_lim = ONE_LIM;
		end else if (lim_raw > DEPTH_LIM) begin
			eff_lim = DEPTH_LIM;
		end else begin
			eff_lim = lim_raw;
		end
		over = (count_ext >= eff_lim);
	end

	// tail slot and head advance, both wrapped at DEPTH
	always_comb begin
		addr_sum = (CW + 1)'(head_q) + (CW + 1)'(count_q);
		if (addr_sum >= DEPTH_SUM) begin
			addr_sum = addr_sum - DEPTH_SUM;
		end
		wr_addr  = addr_sum[AW-1:0];
		head_inc = (head_q == LAST_SLOT) ? '0 : head_q + AW'(1);
	end

	// next head, level and memory control
	always_comb begin
		head_nxt      = head_q;
		count_nxt     = count_q;
		store_ctl     = '0;
		if (in_acc) begin
			if (is_pop) begin
				if (nonempty) begin
					head_nxt        = head_inc;
					count_nxt       = count_q - CW'(1);
					store_ctl.rd_en = 1'b1;
				end
			end else if (over) begin
				// drop oldest: retire the head and append, level unchanged
				if (drop_q) begin
					head_nxt        = head_inc;
					store_ctl.wr_en = 1'b1;
				end
			end else begin
				count_nxt       = count_q + CW'(1);
				store_ctl.wr_en = 1'b1;
			end
		end
	end

	bqd_store #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.ctl     (store_ctl),
		.wr_addr (wr_addr),
		.wr_data (DATA_WIDTH'(payload)),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bqd_pkg::LIMIT_RESET;
			drop_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (bqd_pkg::cfg_idx_t'(cfg_index))
				bqd_pkg::CFG_QUEUE_LIMIT: limit_q <= cfg_data;
				bqd_pkg::CFG_DROP_OLDEST: drop_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// queue state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			lost_q  <= '0;
			peak_q  <= '0;
		end else if (in_acc) begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
			if (!is_pop) begin
				if (over && (lost_q != '1)) begin
					lost_q <= lost_q + bqd_pkg::LOST_W'(1);
				end
				if (count_nxt > peak_q) begin
					peak_q <= count_nxt;
				end
			end
		end
	end

	// result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else begin
			pend_s1 <= rd_issue;
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (in_acc && !rd_issue) begin
				out_valid_q <= 1'b1;
			end else if (out_take || rd_issue) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pend_s1) begin
			pop_valid_q  <= 1'b1;
			pop_data_q   <= bqd_pkg::PAYLOAD_W'(rd_data);
			lost_event_q <= 1'b0;
		end else if (in_acc && !rd_issue) begin
			pop_valid_q  <= 1'b0;
			pop_data_q   <= '0;
			lost_event_q <= !is_pop && over;
		end
	end

	// level fields follow the state left by the last request
	assign out_valid  = out_valid_q;
	assign pop_valid  = pop_valid_q;
	assign pop_data   = pop_data_q;
	assign lost_event = lost_event_q;
	assign fill_level = bqd_pkg::LEVEL_W'(count_q);
	assign is_empty   = !nonempty;
	assign lost_total = lost_q;
	assign peak_level = bqd_pkg::LEVEL_W'(peak_q);

`ifndef SYNTHESIS
	// a pop read never lands on an occupied result register
	a_pend_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("pop read in flight while result register full");

	// every accepted request yields a result or a read in flight
	a_acc_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (out_valid_q || pend_s1))
		else $error("accepted request produced no result");

	// level never exceeds the physical depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue level beyond depth");

	// a returned word is never flagged as an overflow
	a_pop_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pop_valid_q) |-> !lost_event_q)
		else $error("pop result flagged as lost");
`endif

endmodule

/* test/bounded_queue_with_drop_policy_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_queue_with_drop_policy_test
// Self-checking bench for the capped message queue. A short table of
// requests and register writes covers the empty pop, field extremes, the
// zero and oversize limits, both overflow policies and a limit lowered below
// the fill level. Random phases with bursty requests and patterned
// back-pressure follow, one of them filling the queue to its full depth.
// Every result is checked field by field against the table or a behavioural image.
// ----------------------------------------------------------------------------
module bounded_queue_with_drop_policy_test;

	localparam int unsigned QUEUE_DEPTH = 1024;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef logic [bqd_pkg::LEVEL_W-1:0] level_t;

	// one result as seen on the output channel
	typedef struct packed {
		logic                          pop_valid;
		logic [bqd_pkg::PAYLOAD_W-1:0] pop_data;
		logic                          lost_event;
		logic [bqd_pkg::LEVEL_W-1:0]   fill_level;
		logic                          is_empty;
		logic [bqd_pkg::LOST_W-1:0]    lost_total;
		logic [bqd_pkg::LEVEL_W-1:0]   peak_level;
	} queue_result_t;

	// one line of the directed table: a register write or a request
	typedef struct {
		logic                          is_write;
		bqd_pkg::req_t                 kind;
		logic [bqd_pkg::PAYLOAD_W-1:0] word;
		bqd_pkg::cfg_idx_t             reg_index;
		logic [bqd_pkg::LEVEL_W-1:0]   reg_value;
		logic                          typed;
		queue_result_t                 want;
	} plan_row_t;

	localparam int PLAN_ROWS = 26;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic                          cfg_index;
	logic [bqd_pkg::LEVEL_W-1:0]   cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic                          req_type;
	logic [bqd_pkg::PAYLOAD_W-1:0] payload;
	logic                          out_valid;
	logic                          out_stall;
	logic                          pop_valid;
	logic [bqd_pkg::PAYLOAD_W-1:0] pop_data;
	logic                          lost_event;
	logic [bqd_pkg::LEVEL_W-1:0]   fill_level;
	logic                          is_empty;
	logic [bqd_pkg::LOST_W-1:0]    lost_total;
	logic [bqd_pkg::LEVEL_W-1:0]   peak_level;

	// behavioural image of the queue
	logic [bqd_pkg::PAYLOAD_W-1:0] image_words[$];
	logic [bqd_pkg::LOST_W-1:0]    image_lost = '0;
	logic [bqd_pkg::LEVEL_W-1:0]   image_peak = '0;
	logic [bqd_pkg::LEVEL_W-1:0]   image_limit = bqd_pkg::LIMIT_RESET;
	logic                          image_drop_oldest = 1'b0;

	queue_result_t awaited_results[$];
	plan_row_t     plan[0:PLAN_ROWS-1];

	int mismatches = 0;
	int requests = 0;
	int pushes = 0;
	int pops = 0;
	int results_seen = 0;
	int words_returned = 0;
	int reg_writes = 0;
	int burst_left = 0;
	int highest_level = 0;

	// receiver pattern state
	bit hold_request = 1'b0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	bounded_queue_with_drop_policy u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.payload    (payload),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.lost_event (lost_event),
		.fill_level (fill_level),
		.is_empty   (is_empty),
		.lost_total (lost_total),
		.peak_level (peak_level)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// overall time limit
	initial begin
		#5000000;
		$display("bounded_queue_with_drop_policy_test: errors");
		$finish;
	end

	task automatic report(input string msg);
		$display("[%0t] %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report($sformatf("%s mismatch: got %h, want %h", name, got, want));
		end
	endtask

	// advance the queue image by one request and return its result
	function automatic queue_result_t step_queue_image(input bqd_pkg::req_t kind,
			input logic [bqd_pkg::PAYLOAD_W-1:0] word);
		queue_result_t r;
		int limit;
		bit keep;
		r = '0;
		limit = image_limit;
		keep = 1'b1;
		if (limit < 1) begin
			limit = 1;
		end
		if (limit > QUEUE_DEPTH) begin
			limit = QUEUE_DEPTH;
		end
		if (kind == bqd_pkg::REQ_PUSH) begin
			// overflow: count it, then drop either the new word or the oldest
			if (image_words.size() + 1 > limit) begin
				r.lost_event = 1'b1;
				if (image_lost != '1) begin
					image_lost++;
				end
				if (!image_drop_oldest) begin
					keep = 1'b0;
				end else if (image_words.size() > 0) begin
					image_words.delete(0);
				end
			end
			if (keep && image_words.size() < QUEUE_DEPTH) begin
				image_words.insert(image_words.size(), word);
			end
			if (image_words.size() > image_peak) begin
				image_peak = level_t'(image_words.size());
			end
		end else if (image_words.size() > 0) begin
			r.pop_valid = 1'b1;
			r.pop_data = image_words[0];
			image_words.delete(0);
		end
		r.fill_level = level_t'(image_words.size());
		r.is_empty = (image_words.size() == 0);
		r.lost_total = image_lost;
		r.peak_level = image_peak;
		if (image_words.size() > highest_level) begin
			highest_level = image_words.size();
		end
		return r;
	endfunction

	// offer one request and hold it until the queue takes it
	task automatic send_request(input bqd_pkg::req_t kind,
			input logic [bqd_pkg::PAYLOAD_W-1:0] word,
			input logic typed, input queue_result_t typed_want);
		queue_result_t want;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= kind;
		payload <= word;
		do @(posedge clk); while (in_stall);
		want = step_queue_image(kind, word);
		awaited_results.insert(awaited_results.size(), typed ? typed_want : want);
		requests++;
		if (kind == bqd_pkg::REQ_PUSH) begin
			pushes++;
		end else begin
			pops++;
		end
	endtask

	// stop offering and let every pending result come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input bqd_pkg::cfg_idx_t idx,
			input logic [bqd_pkg::LEVEL_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == bqd_pkg::CFG_QUEUE_LIMIT) begin
			image_limit = value;
		end else begin
			image_drop_oldest = value[0];
		end
		reg_writes++;
	endtask

	// bursts of requests separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic run_phase(input int n_items, input int push_pct);
		bqd_pkg::req_t kind;
		logic [bqd_pkg::PAYLOAD_W-1:0] word;
		for (int i = 0; i < n_items; i++) begin
			pace();
			kind = ($urandom_range(0, 99) < push_pct) ? bqd_pkg::REQ_PUSH : bqd_pkg::REQ_POP;
			case ($urandom_range(0, 9))
				0: word = '0;
				1: word = '1;
				2: word = 32'h1 << $urandom_range(0, 31);
				default: word = $urandom;
			endcase
			send_request(kind, word, 1'b0, '0);
		end
	endtask

	// receiver: patterned stalls, with one long hold on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
			if (hold_left == 0) begin
				hold_request = 1'b0;
			end
		end else if (hold_request) begin
			out_stall <= 1'b1;
			hold_left = HOLD_CYCLES;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// compare each delivered result with the oldest expectation
	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pop_valid === 1'b1) begin
				words_returned++;
			end
			if (awaited_results.size() == 0) begin
				report("result delivered with no request pending");
			end else begin
				want = awaited_results[0];
				awaited_results.delete(0);
				check_field("pop_valid", 32'(pop_valid), 32'(want.pop_valid));
				check_field("pop_data", pop_data, want.pop_data);
				check_field("lost_event", 32'(lost_event), 32'(want.lost_event));
				check_field("fill_level", 32'(fill_level), 32'(want.fill_level));
				check_field("is_empty", 32'(is_empty), 32'(want.is_empty));
				check_field("lost_total", lost_total, want.lost_total);
				check_field("peak_level", 32'(peak_level), 32'(want.peak_level));
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bqd_pkg::CFG_QUEUE_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = bqd_pkg::REQ_PUSH;
		payload = '0;
		out_stall = 1'b0;

		// directed table; want fields: pop_valid, pop_data, lost_event,
		// fill_level, is_empty, lost_total, peak_level
		plan = '{
			// pop from empty queue straight after reset
			'{1'b0, bqd_pkg::REQ_POP,  32'h0000_0000, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b1,
				'{1'b0, 32'h0, 1'b0, 11'd0, 1'b1, 32'd0, 11'd0}},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'hFFFF_FFFF, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b1,
				'{1'b0, 32'h0, 1'b0, 11'd1, 1'b0, 32'd0, 11'd1}},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'h0000_0000, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			'{1'b0, bqd_pkg::REQ_POP,  32'h0000_0000, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b1,
				'{1'b1, 32'hFFFF_FFFF, 1'b0, 11'd1, 1'b0, 32'd0, 11'd2}},
			'{1'b0, bqd_pkg::REQ_POP,  32'hFFFF_FFFF, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b1,
				'{1'b1, 32'h0, 1'b0, 11'd0, 1'b1, 32'd0, 11'd2}},
			// limit of zero behaves as one, new word discarded
			'{1'b1, bqd_pkg::REQ_PUSH, 32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'hA5A5_A5A5, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'h5A5A_5A5A, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b1,
				'{1'b0, 32'h0, 1'b1, 11'd1, 1'b0, 32'd1, 11'd2}},
			// drop-oldest, upper data bits set and ignored
			'{1'b1, bqd_pkg::REQ_PUSH, 32'h0, bqd_pkg::CFG_DROP_OLDEST, 11'h7FF, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'h1234_5678, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b1,
				'{1'b0, 32'h0, 1'b1, 11'd1, 1'b0, 32'd2, 11'd2}},
			'{1'b0, bqd_pkg::REQ_POP,  32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b1,
				'{1'b1, 32'h1234_5678, 1'b0, 11'd0, 1'b1, 32'd2, 11'd2}},
			// limit above depth, back to discarding the new word
			'{1'b1, bqd_pkg::REQ_PUSH, 32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'h7FF, 1'b0, '0},
			'{1'b1, bqd_pkg::REQ_PUSH, 32'h0, bqd_pkg::CFG_DROP_OLDEST, 11'h7FE, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'h8000_0000, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'h0000_0001, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'hDEAD_BEEF, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			// limit lowered below the level held
			'{1'b1, bqd_pkg::REQ_PUSH, 32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'd2, 1'b0, '0},
			'{1'b1, bqd_pkg::REQ_PUSH, 32'h0, bqd_pkg::CFG_DROP_OLDEST, 11'd1, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'hCAFE_F00D, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'h0F0F_0F0F, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			'{1'b1, bqd_pkg::REQ_PUSH, 32'h0, bqd_pkg::CFG_DROP_OLDEST, 11'd0, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_PUSH, 32'h1111_1111, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0,
				'0},
			// drain the excess, ending on an empty pop
			'{1'b0, bqd_pkg::REQ_POP,  32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_POP,  32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_POP,  32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0, '0},
			'{1'b0, bqd_pkg::REQ_POP,  32'h0, bqd_pkg::CFG_QUEUE_LIMIT, 11'd0, 1'b0, '0}
		};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed part
		foreach (plan[i]) begin
			if (plan[i].is_write) begin
				write_register(plan[i].reg_index, plan[i].reg_value);
			end else begin
				send_request(plan[i].kind, plan[i].word, plan[i].typed, plan[i].want);
			end
		end

		// random phases with mostly small limits
		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 5))
				0: write_register(bqd_pkg::CFG_QUEUE_LIMIT, 11'd0);
				1: write_register(bqd_pkg::CFG_QUEUE_LIMIT, 11'd1);
				2: write_register(bqd_pkg::CFG_QUEUE_LIMIT, level_t'($urandom_range(2, 8)));
				3: write_register(bqd_pkg::CFG_QUEUE_LIMIT, level_t'($urandom_range(9, 64)));
				4: write_register(bqd_pkg::CFG_QUEUE_LIMIT, 11'h7FF);
				default: write_register(bqd_pkg::CFG_QUEUE_LIMIT,
					level_t'($urandom_range(0, 2047)));
			endcase
			write_register(bqd_pkg::CFG_DROP_OLDEST, level_t'($urandom_range(0, 2047)));
			case ($urandom_range(0, 2))
				0: run_phase(50, 25);
				1: run_phase(50, 50);
				default: run_phase(50, 75);
			endcase
		end

		// fill to full depth while the receiver holds off for a long stretch
		write_register(bqd_pkg::CFG_QUEUE_LIMIT, 11'd1024);
		write_register(bqd_pkg::CFG_DROP_OLDEST, level_t'($urandom_range(0, 2047)));
		hold_request = 1'b1;
		run_phase(1030, 100);

		// tight limit over a full queue, both policies
		write_register(bqd_pkg::CFG_QUEUE_LIMIT, 11'd3);
		write_register(bqd_pkg::CFG_DROP_OLDEST, 11'd1);
		run_phase(60, 50);
		write_register(bqd_pkg::CFG_DROP_OLDEST, 11'd0);
		run_phase(60, 40);

		drain();
		repeat (10) @(negedge clk);
		if (awaited_results.size() != 0) begin
			report($sformatf("%0d results never delivered", awaited_results.size()));
		end

		$display("%0d requests (%0d pushes, %0d pops), %0d results, %0d words returned",
			requests, pushes, pops, results_seen, words_returned);
		$display("%0d register writes, %0d overflows, highest level %0d, %0d mismatches",
			reg_writes, image_lost, highest_level, mismatches);
		if (mismatches == 0) begin
			$display("bounded_queue_with_drop_policy_test: clean");
		end else begin
			$display("bounded_queue_with_drop_policy_test: errors");
		end
		$finish;
	end

endmodule
